/* rtl/core/eqd_pkg.sv */
// Package for the equirectangular distance block: field widths, fixed-point
// constants and the work item passed from the front end to the datapath.
// No dependencies.
`default_nettype none

package eqd_pkg;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int DIST_W  = 36;
    localparam int T_W     = 31;   // folded mean-latitude magnitude
    localparam int DLON_W  = 32;
    localparam int DLAT_W  = 31;
    localparam int ERAW_W  = 46;   // east offset before cosine, micrometers
    localparam int NORTH_W = 45;   // north offset, micrometers
    localparam int SUM_W   = 96;   // sum of squares
    localparam int ROOT_W  = 48;

    localparam int COS_TERMS   = 9;   // Taylor terms of the cosine
    localparam int TERM_STAGES = 7;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int CNT_W  = QPTR_W + 1;

    localparam logic [31:0] HALF_TURN = 32'd1800000000;
    localparam logic [31:0] FULL_TURN = 32'd3600000000;

    localparam logic [63:0] RAD_Q62_PER_HALF_UNIT = 64'd4024455254;
    localparam logic [63:0] Q62_ONE               = 64'h4000_0000_0000_0000;
    localparam logic [13:0] EAST_UM_PER_UNIT      = 14'd11132;
    localparam logic [13:0] NORTH_UM_PER_UNIT     = 14'd11054;

    localparam logic [ROOT_W-1:0] ROUND_HALF = 48'd500;
    localparam logic [ROOT_W-1:0] UM_PER_MM  = 48'd1000;
    localparam int                DIV_SHIFT  = 57;
    localparam logic [63:0]       DIV_RECIP  = (64'd1 << DIV_SHIFT) / 64'd1000;

    typedef struct packed {
        logic [T_W-1:0]    t;
        logic [DLON_W-1:0] dlon;
        logic [DLAT_W-1:0] dlat;
    } eqd_job_t;

endpackage

`default_nettype wire

/* rtl/core/eqd_pos_if.sv */
// Input channel: a pair of positions with valid/ready handshake.
// Depends on eqd_pkg for field widths.
`default_nettype none

interface eqd_pos_if;
    import eqd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] lat_a;
    logic signed [LON_W-1:0] lon_a;
    logic signed [LAT_W-1:0] lat_b;
    logic signed [LON_W-1:0] lon_b;

    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

`default_nettype wire

/* rtl/core/eqd_dist_if.sv */
// Output channel: one distance in millimeters with valid/ready handshake.
// Depends on eqd_pkg for the field width.
`default_nettype none

interface eqd_dist_if;
    import eqd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_mm;

    modport source (output valid, distance_mm, input ready);
    modport sink   (input valid, distance_mm, output ready);
endinterface

`default_nettype wire

/* rtl/core/eqd_mul.sv */
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// No dependencies.
`default_nettype none

module eqd_mul (
    input  logic         clk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] p
);
    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic [127:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= a[31:0]  * b[31:0];
            p01_reg <= a[31:0]  * b[63:32];
            p10_reg <= a[63:32] * b[31:0];
            p11_reg <= a[63:32] * b[63:32];
            p_reg   <= {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                     + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
        end
    end

    assign p = p_reg;
endmodule

`default_nettype wire

/* rtl/core/eqd_front.sv */
// Front end: accepts a position pair, folds the mean latitude and forms the
// absolute coordinate differences. Depends on eqd_pkg and eqd_pos_if.
`default_nettype none

module eqd_front (
    input  logic             clk,
    input  logic             rst_n,
    eqd_pos_if.sink          pos_in,
    output logic             job_valid,
    input  logic             job_ready,
    output eqd_pkg::eqd_job_t job
);
    import eqd_pkg::*;

    logic signed [LAT_W:0] lat_sum;
    logic [LAT_W:0]        lat_mag;
    logic [LAT_W:0]        lat_fold;
    logic signed [LON_W:0] lon_diff;
    logic signed [LAT_W:0] lat_diff;
    eqd_job_t              job_next;
    eqd_job_t              job_reg;
    logic                  valid_reg;

    always_comb
    begin
        lat_sum  = 32'(pos_in.lat_a) + 32'(pos_in.lat_b);
        lat_mag  = lat_sum[LAT_W] ? 32'(-lat_sum) : 32'(lat_sum);
        // beyond 90 degrees: reflect, only |cos| matters
        lat_fold = (lat_mag > HALF_TURN) ? FULL_TURN - lat_mag : lat_mag;
        lon_diff = 33'(pos_in.lon_b) - 33'(pos_in.lon_a);
        lat_diff = 32'(pos_in.lat_b) - 32'(pos_in.lat_a);

        job_next.t    = lat_fold[T_W-1:0];
        job_next.dlon = lon_diff[LON_W] ? 32'(-lon_diff) : lon_diff[DLON_W-1:0];
        job_next.dlat = lat_diff[LAT_W] ? 31'(-lat_diff) : lat_diff[DLAT_W-1:0];
    end

    assign pos_in.ready = !valid_reg || job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pos_in.ready)
        begin
            valid_reg <= pos_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_in.valid && pos_in.ready)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;
endmodule

`default_nettype wire

/* rtl/core/eqd_queue.sv */
// Short queue between the front end and the datapath.
// Depends on eqd_pkg for the job type and depth.
`default_nettype none

module eqd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  eqd_pkg::eqd_job_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output eqd_pkg::eqd_job_t pop_data
);
    import eqd_pkg::*;

    eqd_job_t          buf_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = buf_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("queue count did not drop on pop");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not rise on push");
`endif
endmodule

`default_nettype wire

/* rtl/core/eqd_back.sv */
// Datapath: cosine by Taylor series, east/north offsets, sum of squares,
// digit-by-digit root and rounding to millimeters. Depends on eqd_pkg,
// eqd_mul and eqd_dist_if.
`default_nettype none

module eqd_back #(
    parameter int COS_FRAC_BITS = 30
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  eqd_pkg::eqd_job_t job,
    eqd_dist_if.source        dist_out
);
    import eqd_pkg::*;

    localparam int F   = COS_FRAC_BITS;
    localparam int CW  = F + 1;
    localparam int NST = 4 + COS_TERMS * TERM_STAGES + 4 + 3 + ROOT_W + 5;

    typedef struct packed {
        logic [63:0]        y;
        logic [ERAW_W-1:0]  e;
        logic [NORTH_W-1:0] n;
    } side_t;

    logic           en;
    logic [NST-1:0] vld_reg;

    // whole pipeline advances together; the last stage is the output register
    assign en        = !vld_reg[NST-1] || dist_out.ready;
    assign job_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], job_valid};
        end
    end

    // angle, then its square
    logic [62:0]         x_reg;
    logic [DLON_W-1:0]   dlon_reg;
    logic [DLAT_W-1:0]   dlat_reg;
    logic [127:0]        xsq;
    logic [ERAW_W-1:0]   eraw_b_reg;
    logic [ERAW_W-1:0]   eraw_c_reg;
    logic [NORTH_W-1:0]  north_b_reg;
    logic [NORTH_W-1:0]  north_c_reg;
    side_t               it_sd [0:COS_TERMS];
    logic [63:0]         it_c  [0:COS_TERMS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg       <= 63'(job.t) * 63'(RAD_Q62_PER_HALF_UNIT);
            dlon_reg    <= job.dlon;
            dlat_reg    <= job.dlat;
            eraw_b_reg  <= ERAW_W'(dlon_reg) * ERAW_W'(EAST_UM_PER_UNIT);
            north_b_reg <= NORTH_W'(dlat_reg) * NORTH_W'(NORTH_UM_PER_UNIT);
            eraw_c_reg  <= eraw_b_reg;
            north_c_reg <= north_b_reg;
            it_sd[0].y  <= xsq[125:62];
            it_sd[0].e  <= eraw_c_reg;
            it_sd[0].n  <= north_c_reg;
            it_c[0]     <= Q62_ONE;
        end
    end

    eqd_mul u_mul_xsq (
        .clk (clk),
        .en  (en),
        .a   ({1'b0, x_reg}),
        .b   ({1'b0, x_reg}),
        .p   (xsq)
    );

    // one Taylor term per group: c = 1 - (y*c >> 62) / d
    for (genvar g = 0; g < COS_TERMS; g++)
    begin : g_term
        localparam int N  = COS_TERMS - g;
        localparam int D  = (2 * N) * (2 * N - 1);
        localparam int L2 = $clog2(D + 1) - 1;
        localparam int K  = 63 + L2;
        localparam logic [127:0] RECIP_W = (128'd1 << K) / 128'(D);
        localparam logic [63:0]  RECIP   = RECIP_W[63:0];

        side_t        sd_reg [1:6];
        logic [63:0]  m_reg  [3:6];
        logic [63:0]  q_reg;
        logic [127:0] yc;
        logic [127:0] mr;
        logic [63:0]  rem;
        logic [63:0]  qf;

        eqd_mul u_mul_yc (
            .clk (clk),
            .en  (en),
            .a   (it_sd[g].y),
            .b   (it_c[g]),
            .p   (yc)
        );

        eqd_mul u_mul_rcp (
            .clk (clk),
            .en  (en),
            .a   (m_reg[3]),
            .b   (RECIP),
            .p   (mr)
        );

        // reciprocal estimate is low by at most one
        always_comb
        begin
            rem = m_reg[6] - 64'(q_reg * 64'(D));
            qf  = (rem >= 64'(D)) ? q_reg + 64'd1 : q_reg;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd_reg[1] <= it_sd[g];
                for (int k = 2; k <= 6; k++)
                begin
                    sd_reg[k] <= sd_reg[k-1];
                end
                m_reg[3] <= yc[125:62];
                m_reg[4] <= m_reg[3];
                m_reg[5] <= m_reg[4];
                m_reg[6] <= m_reg[5];
                q_reg    <= 64'(mr >> K);
                it_sd[g+1] <= sd_reg[6];
                it_c[g+1]  <= (qf >= Q62_ONE) ? 64'd0 : Q62_ONE - qf;
            end
        end
    end

    // round cosine, scale east offset
    logic [CW-1:0]      cosq_reg;
    logic [ERAW_W-1:0]  eraw_d_reg;
    logic [NORTH_W-1:0] nd_reg [1:4];
    logic [127:0]       ep;
    logic [ERAW_W-1:0]  east_reg;
    logic [127:0]       pee;
    logic [127:0]       pnn;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cosq_reg   <= CW'((it_c[COS_TERMS] + (64'd1 << (61 - F))) >> (62 - F));
            eraw_d_reg <= it_sd[COS_TERMS].e;
            nd_reg[1]  <= it_sd[COS_TERMS].n;
            nd_reg[2]  <= nd_reg[1];
            nd_reg[3]  <= nd_reg[2];
            nd_reg[4]  <= nd_reg[3];
            east_reg   <= ERAW_W'((ep + (128'd1 << (F - 1))) >> F);
        end
    end

    eqd_mul u_mul_east (
        .clk (clk),
        .en  (en),
        .a   (64'(eraw_d_reg)),
        .b   (64'(cosq_reg)),
        .p   (ep)
    );

    eqd_mul u_mul_ee (
        .clk (clk),
        .en  (en),
        .a   (64'(east_reg)),
        .b   (64'(east_reg)),
        .p   (pee)
    );

    eqd_mul u_mul_nn (
        .clk (clk),
        .en  (en),
        .a   (64'(nd_reg[4])),
        .b   (64'(nd_reg[4])),
        .p   (pnn)
    );

    // root, one bit per stage
    logic [SUM_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= SUM_W'(pee) + SUM_W'(pnn);
            root_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_root
        localparam int B = ROOT_W - 1 - i;

        logic [SUM_W-1:0] trial;

        always_comb
        begin
            trial = (SUM_W'(root_reg[i]) << (B + 1)) + (SUM_W'(1) << (2 * B));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[i] >= trial)
                begin
                    rem_reg[i+1]  <= rem_reg[i] - trial;
                    root_reg[i+1] <= root_reg[i] | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[i+1]  <= rem_reg[i];
                    root_reg[i+1] <= root_reg[i];
                end
            end
        end
    end

    // micrometers to millimeters, halves up
    logic [ROOT_W-1:0] v_reg [1:4];
    logic [127:0]      pd;
    logic [ROOT_W-1:0] qd_reg;
    logic [ROOT_W-1:0] rd;
    logic [DIST_W-1:0] dist_reg;

    assign rd = v_reg[4] - ROOT_W'(qd_reg * UM_PER_MM);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[1] <= root_reg[ROOT_W] + ROUND_HALF;
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3];
            qd_reg   <= ROOT_W'(pd >> DIV_SHIFT);
            dist_reg <= DIST_W'((rd >= UM_PER_MM) ? qd_reg + ROOT_W'(1) : qd_reg);
        end
    end

    eqd_mul u_mul_div (
        .clk (clk),
        .en  (en),
        .a   (64'(v_reg[1])),
        .b   (DIV_RECIP),
        .p   (pd)
    );

    assign dist_out.valid       = vld_reg[NST-1];
    assign dist_out.distance_mm = dist_reg;
endmodule

`default_nettype wire

/* rtl/core/equirect_distance.sv */
// Equirectangular distance between two positions, top level.
// Depends on eqd_pkg, eqd_pos_if, eqd_dist_if, eqd_front, eqd_queue, eqd_back.
//
// Usage:
//   pos_in   : one request carries lat_a, lon_a, lat_b, lon_b in signed
//              1e-7 degree units. Taken at an edge with valid and ready high.
//   dist_out : one result per request, distance_mm, rounded millimeters.
//              Results leave in request order.
// Throughput: one request per cycle while dist_out is not stalled. The datapath is a single
//   127-stage pipeline (nine Taylor terms of seven stages each, a 48-stage
//   root, a handful of multiply stages), each stage built around at most a
//   split 64x64 multiply or one 96-bit compare and subtract.
// Path: a request passes one front register, one queue slot and the 127
//   datapath stages before its result shows on dist_out; stalls add to that.
// Stall: while dist_out.valid is high and ready low, the datapath holds.
//   The front end and the four-entry queue keep taking requests until the
//   queue fills, then pos_in.ready drops.
// Reset: rst_n clears all valid and queue state; no result is pending and
//   the block takes requests in the first cycle after reset.
`default_nettype none

module equirect_distance #(
    parameter int COS_FRAC_BITS = 30
) (
    input  logic       clk,
    input  logic       rst_n,
    eqd_pos_if.sink    pos_in,
    eqd_dist_if.source dist_out
);
    import eqd_pkg::*;

    // front end to queue
    logic     fq_valid;
    logic     fq_ready;
    eqd_job_t fq_job;

    // queue to datapath
    logic     qb_valid;
    logic     qb_ready;
    eqd_job_t qb_job;

    // fold latitude, take differences
    eqd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos_in    (pos_in),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // decouple front end from datapath stalls
    eqd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_job)
    );

    // cosine, offsets, root and rounding
    eqd_back #(
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .dist_out  (dist_out)
    );
endmodule

`default_nettype wire

/* bench/equirect_distance_test.sv */
// Self-checking bench for equirect_distance: drives point pairs, predicts the
// distance in millimeters and compares every result in order.
// Depends on eqd_pkg, eqd_pos_if, eqd_dist_if and the equirect_distance RTL.
`default_nettype none

module equirect_distance_test;
    timeunit 1ns;
    timeprecision 1ps;
    import eqd_pkg::*;

    localparam int COS_F      = 30;
    localparam int LATENCY    = 128;
    localparam int RAND_ITEMS = 1100;
    localparam int CYCLE_CAP  = 400000;

    // One row of the directed table; want_dist < 0 means use the predictor.
    typedef struct {
        logic signed [LAT_W-1:0] lat_a;
        logic signed [LON_W-1:0] lon_a;
        logic signed [LAT_W-1:0] lat_b;
        logic signed [LON_W-1:0] lon_b;
        longint                  want_dist;
    } pair_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    eqd_pos_if  pos_in();
    eqd_dist_if dist_out();

    equirect_distance #(.COS_FRAC_BITS(COS_F)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pos_in  (pos_in.sink),
        .dist_out(dist_out.source)
    );

    always #2 clk = ~clk;

    logic [DIST_W-1:0] expected_dist[$];
    int                error_count = 0;
    int                result_count = 0;
    int                cycle_count = 0;
    bit                stim_done = 1'b0;
    bit                hold_off = 1'b0;    // long receiver stall in progress

    // ---------------------------------------------------------------------
    // Distance predictor. Integer steps mirror the fixed-point definition:
    // folded mean latitude, Q62 Taylor cosine, rounded Q(COS_F) cosine,
    // east and north offsets in micrometers, floor root, rounded to mm.
    // ---------------------------------------------------------------------
    function automatic logic [63:0] cos_mag_q(longint lat_sum);
        logic [63:0]  t;
        logic [63:0]  x;
        logic [63:0]  y;
        logic [63:0]  c;
        logic [63:0]  p;
        logic [127:0] prod;
        t = (lat_sum < 0) ? 64'(-lat_sum) : 64'(lat_sum);
        if (t > 64'd1800000000)
            t = 64'd3600000000 - t;
        x = t * 64'd4024455254;
        prod = 128'(x) * 128'(x);
        y = 64'(prod >> 62);
        c = 64'h4000_0000_0000_0000;
        for (int n = 9; n >= 1; n--)
        begin
            prod = 128'(y) * 128'(c);
            p = 64'(prod >> 62) / 64'((2 * n) * (2 * n - 1));
            c = (p >= 64'h4000_0000_0000_0000) ? 64'd0 : 64'h4000_0000_0000_0000 - p;
        end
        return (c + (64'd1 << (61 - COS_F))) >> (62 - COS_F);
    endfunction

    function automatic logic [DIST_W-1:0] ground_distance(
        logic signed [LAT_W-1:0] lat_a, logic signed [LON_W-1:0] lon_a,
        logic signed [LAT_W-1:0] lat_b, logic signed [LON_W-1:0] lon_b);
        longint       la;
        longint       lb;
        longint       oa;
        longint       ob;
        logic [63:0]  cq;
        logic [63:0]  e_raw;
        logic [63:0]  east;
        logic [63:0]  north;
        logic [127:0] sum;
        logic [63:0]  root;
        logic [63:0]  cand;
        la = lat_a;
        lb = lat_b;
        oa = lon_a;
        ob = lon_b;
        cq = cos_mag_q(la + lb);
        e_raw = 64'((ob >= oa) ? ob - oa : oa - ob) * 64'd11132;
        east = 64'(((128'(e_raw) * 128'(cq)) + (128'd1 << (COS_F - 1))) >> COS_F);
        north = 64'((lb >= la) ? lb - la : la - lb) * 64'd11054;
        sum = 128'(east) * 128'(east) + 128'(north) * 128'(north);
        root = 64'd0;
        for (int b = 47; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= sum)
                root = cand;
        end
        return DIST_W'((root + 64'd500) / 64'd1000);
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Most often no gap, else mostly a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------------
    // Directed table: extremes, reflection past 90 degrees, antimeridian,
    // full bit patterns. Rows with a known answer carry it.
    // ---------------------------------------------------------------------
    pair_row_t directed_rows[] = '{
        '{31'sd0, 32'sd0, 31'sd0, 32'sd0, 64'sd0},                // same point
        '{31'sd0, 32'sd0, 31'sd10000000, 32'sd0, 64'sd110540000}, // 1 deg north
        '{31'sd0, 32'sd0, 31'sd0, 32'sd10000000, -1},             // 1 deg east
        '{31'sd900000000, 32'sd0, 31'sd900000000, 32'sd1800000000, -1}, // pole
        '{-31'sd900000000, 32'sd0, 31'sd900000000, 32'sd0, -1},
        '{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000, -1},
        '{31'sd0, 32'sd1799999999, 31'sd0, -32'sd1799999999, -1}, // antimeridian
        '{31'sd450000000, 32'sd5, 31'sd450000000, -32'sd5, -1},
        '{31'sd1073741823, 32'sd2147483647, -31'sd1073741824, -32'sd2147483648, -1},
        '{31'sd1073741823, -32'sd2147483648, 31'sd1073741823, 32'sd2147483647, -1},
        '{-31'sd1073741824, 32'sd2147483647, -31'sd1073741824, -32'sd2147483648, -1},
        '{31'sd950000000, 32'sd0, 31'sd950000000, 32'sd100000000, -1}, // past 90
        '{-31'sd1, -32'sd1, 31'sd0, 32'sd0, -1},
        '{31'sd123456789, 32'sd987654321, -31'sd234567890, -32'sd876543210, -1},
        '{31'sd0, 32'sd0, 31'sd1, 32'sd1, -1}
    };

    // Offer one request and hold it until it is taken. Valid stays up after
    // the accepting edge so that a following request can go back to back;
    // drop it before any gap.
    task automatic send_pair(input logic signed [LAT_W-1:0] lat_a,
                             input logic signed [LON_W-1:0] lon_a,
                             input logic signed [LAT_W-1:0] lat_b,
                             input logic signed [LON_W-1:0] lon_b,
                             input longint want, input bit use_gap);
        int gap;
        gap = use_gap ? gap_len() : 0;
        if (gap > 0)
        begin
            pos_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pos_in.valid <= 1'b1;
        pos_in.lat_a <= lat_a;
        pos_in.lon_a <= lon_a;
        pos_in.lat_b <= lat_b;
        pos_in.lon_b <= lon_b;
        @(posedge clk);
        while (!pos_in.ready)
            @(posedge clk);
        expected_dist.push_back(want >= 0 ? DIST_W'(want)
                                          : ground_distance(lat_a, lon_a, lat_b, lon_b));
    endtask

    // Random latitude: in range mostly, any bit pattern sometimes.
    function automatic logic signed [LAT_W-1:0] rand_lat();
        if ($urandom_range(0, 9) == 0)
            return LAT_W'($urandom);
        return LAT_W'(int'($urandom_range(0, 1800000000)) - 900000000);
    endfunction

    function automatic logic signed [LON_W-1:0] rand_lon();
        if ($urandom_range(0, 9) == 0)
            return LON_W'($urandom);
        return LON_W'(longint'($urandom_range(0, 3600000000)) - 64'sd1800000000);
    endfunction

    // ---------------------------------------------------------------------
    // Sender: directed rows, a burst during the long receiver stall, a
    // drain pause, then random requests.
    // ---------------------------------------------------------------------
    initial
    begin : sender
        logic signed [LAT_W-1:0] la;
        logic signed [LON_W-1:0] oa;
        pos_in.valid = 1'b0;
        pos_in.lat_a = '0;
        pos_in.lon_a = '0;
        pos_in.lat_b = '0;
        pos_in.lon_b = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_pair(directed_rows[i].lat_a, directed_rows[i].lon_a,
                      directed_rows[i].lat_b, directed_rows[i].lon_b,
                      directed_rows[i].want_dist, 1'b1);

        // Keep offering back to back while the receiver holds off.
        hold_off <= 1'b1;
        for (int i = 0; i < 200; i++)
            send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon(), -1, 1'b0);

        // Pause until every outstanding result has come back.
        pos_in.valid <= 1'b0;
        while (expected_dist.size() != 0)
            @(posedge clk);

        for (int i = 0; i < RAND_ITEMS - 200; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                // nearby pair: short offsets exercise rounding
                la = rand_lat();
                oa = rand_lon();
                send_pair(la, oa, LAT_W'(la + LAT_W'($urandom_range(0, 2000)) - 1000),
                          LON_W'(oa + LON_W'($urandom_range(0, 2000)) - 1000), -1,
                          i % 300 > 30);
            end
            else
                send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon(), -1,
                          i % 300 > 30);
        end
        pos_in.valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // Receiver ready: random stalls, one long hold-off counted in cycles.
    initial
    begin : receiver
        int gap;
        dist_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                dist_out.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            gap = gap_len();
            if (gap == 0 || cycle_count % 2000 < 200)
            begin
                dist_out.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                dist_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                dist_out.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && dist_out.valid && dist_out.ready)
        begin
            result_count++;
            if (expected_dist.size() == 0)
                report_mismatch($sformatf("unexpected result %0d", dist_out.distance_mm));
            else if (dist_out.distance_mm !== expected_dist[0])
            begin
                report_mismatch($sformatf("result %0d: distance_mm %0d, want %0d",
                                          result_count, dist_out.distance_mm,
                                          expected_dist[0]));
                void'(expected_dist.pop_front());
            end
            else
                void'(expected_dist.pop_front());
        end
    end

    // Finish: drain, settle past the latency, then judge; a cap guards hangs.
    initial
    begin : finisher
        wait (stim_done);
        while (expected_dist.size() != 0 && cycle_count < CYCLE_CAP)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (error_count == 0 && expected_dist.size() == 0 && cycle_count < CYCLE_CAP)
            $display("equirect_distance: match");
        else
            $display("equirect_distance: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP + 4 * LATENCY)
        begin
            $display("equirect_distance: mismatch");
            $finish;
        end
    end
endmodule

`default_nettype wire

/* sim.f */
rtl/core/eqd_pkg.sv
rtl/core/eqd_pos_if.sv
rtl/core/eqd_dist_if.sv
rtl/core/eqd_mul.sv
rtl/core/eqd_front.sv
rtl/core/eqd_queue.sv
rtl/core/eqd_back.sv
rtl/core/equirect_distance.sv
bench/equirect_distance_test.sv
